### hw/rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

  localparam int DEF_ENTRIES = 16;
  localparam int DEF_PORTS   = 8;
  localparam int IP_W        = 32;
  localparam int SLOT_W      = 4;
  localparam int LEN_W       = 6;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/lpm_ram.sv
`default_nettype none

module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/longest_prefix_match_table.sv
// IPv4 longest-prefix-match routing table.
//
// Input channel (in_valid/in_ready): one item is either a slot write
// (in_kind = 0) or an address lookup (in_kind = 1). Result channel
// (out_valid/out_ready): exactly one item per input item, in order.
// A write returns an all-zero acknowledgement; a lookup returns hit,
// winning slot, prefix length, next hop and port (all zero on a miss).
//
// Route data sits in a single-port-write, registered-read RAM; valid bits
// are flip-flops. A lookup walks the slots one per cycle through a
// three-stage read / match / select pipeline, then loads its result
// into the output register; a write skips the scan. One item is in
// work at a time: in_ready is high only while the block is idle.
// The result sits in an output register; while the receiver stalls, the
// finished item waits there and the next item can be taken and worked on,
// holding only at its final step until the register frees up.
// Reset clears all valid bits, so every slot misses until written.
// Writes to slot indexes at or above ENTRIES are ignored but acknowledged.

`default_nettype none

module longest_prefix_match_table
  import lpm_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int PORTS   = DEF_PORTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic                       in_kind,
  input  wire logic [SLOT_W-1:0]          in_slot_index,
  input  wire logic                       in_slot_valid,
  input  wire logic [IP_W-1:0]            in_route_prefix_in,
  input  wire logic [IP_W-1:0]            in_route_mask_in,
  input  wire logic [IP_W-1:0]            in_route_gateway_in,
  input  wire logic [$clog2(PORTS)-1:0]   in_route_port_in,
  input  wire logic [IP_W-1:0]            in_lookup_address,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic                       out_hit,
  output      logic [SLOT_W-1:0]          out_matched_slot,
  output      logic [LEN_W-1:0]           out_prefix_length,
  output      logic [IP_W-1:0]            out_next_hop,
  output      logic [$clog2(PORTS)-1:0]   out_out_port
);

  localparam int IdxW  = $clog2(ENTRIES);
  localparam int PortW = $clog2(PORTS);
  localparam int DataW = 3 * IP_W + PortW;
  localparam int WideW = IdxW + SLOT_W;

  function automatic logic [LEN_W-1:0] lead_ones(input logic [IP_W-1:0] m);
    logic [IP_W-1:0]  x;
    logic [LEN_W-1:0] n;
    x = ~m;
    n = '0;
    if (x == '0) begin
      n = LEN_W'(IP_W);
    end else begin
      if (x[31:16] == 16'd0) begin
        n = n + LEN_W'(16);
        x = {x[15:0], 16'd0};
      end
      if (x[31:24] == 8'd0) begin
        n = n + LEN_W'(8);
        x = {x[23:0], 8'd0};
      end
      if (x[31:28] == 4'd0) begin
        n = n + LEN_W'(4);
        x = {x[27:0], 4'd0};
      end
      if (x[31:30] == 2'd0) begin
        n = n + LEN_W'(2);
        x = {x[29:0], 2'd0};
      end
      if (!x[31]) begin
        n = n + LEN_W'(1);
      end
    end
    return n;
  endfunction

  state_t state_r, state_nxt;

  logic               in_fire;
  logic               out_free;
  logic               issue;
  logic               load_out;
  logic               wr_en;
  logic [WideW-1:0]   wr_idx_wide;
  logic [IdxW-1:0]    wr_addr;
  logic [DataW-1:0]   wr_data;
  logic [DataW-1:0]   rd_data;

  logic [ENTRIES-1:0] valid_r;
  logic [IP_W-1:0]    addr_r;
  logic [IdxW-1:0]    scan_r;
  logic               scan_end_r;

  logic               rd_v_r;
  logic               rd_last_r;
  logic               rd_ev_r;
  logic [IdxW-1:0]    rd_idx_r;

  logic [IP_W-1:0]    rd_prefix;
  logic [IP_W-1:0]    rd_mask;
  logic [IP_W-1:0]    rd_gw;
  logic [PortW-1:0]   rd_port;

  logic               a_v_r;
  logic               a_last_r;
  logic               a_match_r;
  logic [IdxW-1:0]    a_idx_r;
  logic [LEN_W-1:0]   a_len_r;
  logic [IP_W-1:0]    a_gw_r;
  logic [PortW-1:0]   a_port_r;

  logic               found_r;
  logic [IdxW-1:0]    best_idx_r;
  logic [LEN_W-1:0]   best_len_r;
  logic [IP_W-1:0]    best_gw_r;
  logic [PortW-1:0]   best_port_r;
  logic [WideW-1:0]   best_idx_wide;

  logic               out_valid_r;
  logic               out_hit_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [LEN_W-1:0]   out_len_r;
  logic [IP_W-1:0]    out_hop_r;
  logic [PortW-1:0]   out_port_r;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_kind == KIND_LOOKUP) ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (a_v_r && a_last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: issue    = !scan_end_r;
      S_DONE: load_out = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table write path
  assign wr_idx_wide = {{IdxW{1'b0}}, in_slot_index};
  assign wr_addr     = wr_idx_wide[IdxW-1:0];
  assign wr_en       = in_fire && (in_kind == KIND_WRITE) &&
                       (wr_idx_wide < WideW'(ENTRIES));
  assign wr_data     = {in_route_prefix_in, in_route_mask_in,
                        in_route_gateway_in, in_route_port_in};

  lpm_ram #(
    .WIDTH (DataW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (scan_r),
    .rdata (rd_data)
  );

  assign {rd_prefix, rd_mask, rd_gw, rd_port} = rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= in_slot_valid;
    end
  end

  // scan counter and read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_end_r <= 1'b0;
      rd_v_r     <= 1'b0;
    end else begin
      rd_v_r <= issue;
      if (in_fire) begin
        scan_end_r <= 1'b0;
      end else if (issue && (scan_r == IdxW'(ENTRIES - 1))) begin
        scan_end_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_r <= '0;
      addr_r <= in_lookup_address;
    end else if (issue) begin
      scan_r <= scan_r + IdxW'(1);
    end
    rd_last_r <= (scan_r == IdxW'(ENTRIES - 1));
    rd_ev_r   <= valid_r[scan_r];
    rd_idx_r  <= scan_r;
  end

  // match stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_last_r  <= rd_last_r;
    a_match_r <= rd_ev_r && ((rd_prefix & rd_mask) == (addr_r & rd_mask));
    a_idx_r   <= rd_idx_r;
    a_len_r   <= lead_ones(rd_mask);
    a_gw_r    <= rd_gw;
    a_port_r  <= rd_port;
  end

  // select stage, strict compare keeps the lowest index on a tie
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_fire) begin
      found_r <= 1'b0;
    end else if (a_v_r && a_match_r) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (a_v_r && a_match_r && (!found_r || (a_len_r > best_len_r))) begin
      best_idx_r  <= a_idx_r;
      best_len_r  <= a_len_r;
      best_gw_r   <= a_gw_r;
      best_port_r <= a_port_r;
    end
  end

  // output register
  assign best_idx_wide = {{SLOT_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r  <= found_r;
      out_slot_r <= found_r ? best_idx_wide[SLOT_W-1:0] : '0;
      out_len_r  <= found_r ? best_len_r : '0;
      out_hop_r  <= found_r ? best_gw_r : '0;
      out_port_r <= found_r ? best_port_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_matched_slot  = out_slot_r;
  assign out_prefix_length = out_len_r;
  assign out_next_hop      = out_hop_r;
  assign out_out_port      = out_port_r;

endmodule

`default_nettype wire

### hw/rtl/lpm_checker.sv
`default_nettype none

module lpm_checker
  import lpm_pkg::*;
#(
  parameter int PORTS = DEF_PORTS
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     out_hit,
  input wire logic [SLOT_W-1:0]        out_matched_slot,
  input wire logic [LEN_W-1:0]         out_prefix_length,
  input wire logic [IP_W-1:0]          out_next_hop,
  input wire logic [$clog2(PORTS)-1:0] out_out_port
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accepting an item");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_next_hop) && $stable(out_matched_slot))
    else $error("stalled result changed");

  // misses and write acks carry all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_matched_slot == '0 &&
      out_prefix_length == '0 && out_next_hop == '0 && out_out_port == '0)
    else $error("nonzero fields on a miss");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_prefix_length <= LEN_W'(IP_W))
    else $error("prefix length out of range");

endmodule

bind longest_prefix_match_table lpm_checker #(.PORTS(PORTS)) u_lpm_checker (.*);

`default_nettype wire

### dv/lpm_checker.sv
`default_nettype none

module lpm_scoreboard
  import lpm_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int PORT_W  = $clog2(DEF_PORTS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic              in_kind,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  input  wire logic              in_slot_valid,
  input  wire logic [IP_W-1:0]   in_route_prefix_in,
  input  wire logic [IP_W-1:0]   in_route_mask_in,
  input  wire logic [IP_W-1:0]   in_route_gateway_in,
  input  wire logic [PORT_W-1:0] in_route_port_in,
  input  wire logic [IP_W-1:0]   in_lookup_address,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic              out_hit,
  input  wire logic [SLOT_W-1:0] out_matched_slot,
  input  wire logic [LEN_W-1:0]  out_prefix_length,
  input  wire logic [IP_W-1:0]   out_next_hop,
  input  wire logic [PORT_W-1:0] out_out_port,
  output int                     mismatches,
  output int                     pending,
  output int                     hits
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
    logic [IP_W-1:0]   hop;
    logic [PORT_W-1:0] port;
  } route_result_t;

  logic              rt_valid   [ENTRIES];
  logic [IP_W-1:0]   rt_prefix  [ENTRIES];
  logic [IP_W-1:0]   rt_mask    [ENTRIES];
  logic [IP_W-1:0]   rt_gateway [ENTRIES];
  logic [PORT_W-1:0] rt_port    [ENTRIES];

  route_result_t route_results_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    hits       = 0;
  end

  function automatic int unsigned mask_length(logic [IP_W-1:0] m);
    int unsigned n;
    n = 0;
    while (n < IP_W && m[IP_W-1]) begin
      n++;
      m = m << 1;
    end
    return n;
  endfunction

  // longest mask wins, strict compare keeps the lowest index on a tie
  function automatic route_result_t predict_route(logic [IP_W-1:0] addr);
    route_result_t r;
    int unsigned   len;
    int unsigned   best_len;
    r        = '0;
    best_len = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (rt_valid[i] && ((rt_prefix[i] & rt_mask[i]) == (addr & rt_mask[i]))) begin
        len = mask_length(rt_mask[i]);
        if (!r.hit || len > best_len) begin
          best_len = len;
          r.hit    = 1'b1;
          r.slot   = SLOT_W'(i);
          r.len    = LEN_W'(len);
          r.hop    = rt_gateway[i];
          r.port   = rt_port[i];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    route_result_t got;
    route_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) rt_valid[i] = 1'b0;
      route_results_q.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_kind == KIND_WRITE) begin
          if (in_slot_index < ENTRIES) begin
            rt_valid[in_slot_index]   = in_slot_valid;
            rt_prefix[in_slot_index]  = in_route_prefix_in;
            rt_mask[in_slot_index]    = in_route_mask_in;
            rt_gateway[in_slot_index] = in_route_gateway_in;
            rt_port[in_slot_index]    = in_route_port_in;
          end
          route_results_q.push_back('0);
        end else begin
          want = predict_route(in_lookup_address);
          if (want.hit) hits++;
          route_results_q.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got = {out_hit, out_matched_slot, out_prefix_length, out_next_hop, out_out_port};
        if (route_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected item hit=%0d slot=%0d len=%0d hop=%h port=%0d",
                     $realtime, got.hit, got.slot, got.len, got.hop, got.port);
        end else begin
          want = route_results_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp hit=%0d slot=%0d len=%0d hop=%h port=%0d",
                       $realtime, want.hit, want.slot, want.len, want.hop, want.port);
              $display("%0t:          got hit=%0d slot=%0d len=%0d hop=%h port=%0d",
                       $realtime, got.hit, got.slot, got.len, got.hop, got.port);
            end
          end
        end
      end
      pending <= route_results_q.size();
    end
  end

endmodule

`default_nettype wire

### dv/tb_longest_prefix_match_table.sv
`default_nettype none

module tb_longest_prefix_match_table
  import lpm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PORT_W = $clog2(DEF_PORTS);

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  kind_t             in_kind = KIND_WRITE;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic              in_slot_valid = 1'b0;
  logic [IP_W-1:0]   in_route_prefix_in = '0;
  logic [IP_W-1:0]   in_route_mask_in = '0;
  logic [IP_W-1:0]   in_route_gateway_in = '0;
  logic [PORT_W-1:0] in_route_port_in = '0;
  logic [IP_W-1:0]   in_lookup_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_matched_slot;
  logic [LEN_W-1:0]  out_prefix_length;
  logic [IP_W-1:0]   out_next_hop;
  logic [PORT_W-1:0] out_out_port;

  int mismatches;
  int pending;
  int hits;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int n_writes = 0;
  int n_lookups = 0;

  logic [IP_W-1:0] seen_prefix [DEF_ENTRIES];
  logic [IP_W-1:0] seen_mask   [DEF_ENTRIES];

  longest_prefix_match_table DUT (.*);

  lpm_scoreboard checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic push_item(kind_t k, logic [SLOT_W-1:0] idx, logic v,
                           logic [IP_W-1:0] p, logic [IP_W-1:0] m,
                           logic [IP_W-1:0] g, logic [PORT_W-1:0] port,
                           logic [IP_W-1:0] addr);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid            <= 1'b1;
    in_kind             <= k;
    in_slot_index       <= idx;
    in_slot_valid       <= v;
    in_route_prefix_in  <= p;
    in_route_mask_in    <= m;
    in_route_gateway_in <= g;
    in_route_port_in    <= port;
    in_lookup_address   <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_route(logic [SLOT_W-1:0] idx, logic v, logic [IP_W-1:0] p,
                             logic [IP_W-1:0] m, logic [IP_W-1:0] g,
                             logic [PORT_W-1:0] port);
    seen_prefix[idx] = p;
    seen_mask[idx]   = m;
    n_writes++;
    push_item(KIND_WRITE, idx, v, p, m, g, port, $urandom);
  endtask

  task automatic find_route(logic [IP_W-1:0] addr);
    n_lookups++;
    push_item(KIND_LOOKUP, SLOT_W'($urandom), 1'($urandom), $urandom, $urandom,
              $urandom, PORT_W'($urandom), addr);
  endtask

  initial begin
    int              idle_by_phase [4];
    int              stall_by_phase [4];
    int unsigned     s;
    int unsigned     len;
    logic [IP_W-1:0] m;
    idle_by_phase  = '{0, 65, 0, 29};
    stall_by_phase = '{0, 0, 65, 29};
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      seen_prefix[i] = $urandom;
      seen_mask[i]   = $urandom;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table misses
    find_route(32'hFFFF_FFFF);
    find_route(32'h0000_0000);
    // default route matches everything
    write_route(4'd0, 1'b1, 32'hDEAD_BEEF, 32'h0000_0000, 32'h0A00_0001, 3'd0);
    find_route(32'h1234_5678);
    write_route(4'd15, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hFFFF_FFFF, 3'd7);
    find_route(32'hC0A8_01FE);
    write_route(4'd3, 1'b1, 32'hC0A8_0000, 32'hFFFF_0000, 32'h0A00_0003, 3'd3);
    write_route(4'd2, 1'b1, 32'hC0A8_0155, 32'hFFFF_FFFF, 32'h0A00_0002, 3'd5);
    find_route(32'hC0A8_0155);
    find_route(32'hC0A8_0156);
    find_route(32'hC0A8_FF00);
    // equal length as slot 15, lower index takes it
    write_route(4'd7, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0007, 3'd1);
    find_route(32'hC0A8_0101);
    // non-contiguous mask counts leading ones only
    write_route(4'd9, 1'b1, 32'h0A00_0B00, 32'hFF00_FF00, 32'h0A00_0009, 3'd6);
    find_route(32'h0A7F_0BAA);
    // cleared slots never match
    write_route(4'd7, 1'b0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0007, 3'd1);
    find_route(32'hC0A8_0101);
    write_route(4'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    find_route(32'h0102_0304);
    write_route(4'd1, 1'b1, 32'h0000_0000, 32'h8000_0000, 32'h0A00_0001, 3'd2);
    find_route(32'h7FFF_FFFF);
    write_route(4'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000, 3'd7);
    find_route(32'hFFFF_FFFE);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct     = stall_by_phase[ph];
      repeat (150) begin
        s = $urandom_range(DEF_ENTRIES - 1);
        if ($urandom_range(99) < 40) begin
          len = $urandom_range(32);
          if ($urandom_range(99) < 85)
            m = (len == 0) ? '0 : ~32'h0 << (32 - len);
          else
            m = $urandom;
          write_route(SLOT_W'(s), $urandom_range(99) < 85, $urandom, m, $urandom,
                      PORT_W'($urandom_range(7)));
        end else if ($urandom_range(99) < 85) begin
          find_route((seen_prefix[s] & seen_mask[s]) | ($urandom & ~seen_mask[s]));
        end else begin
          find_route($urandom);
        end
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);

    $display("summary: %0d slot writes, %0d lookups with %0d hits", n_writes, n_lookups, hits);
    $display("summary: pacing ran free, with sender gaps, receiver stalls and both");
    if (mismatches == 0 && pending == 0)
      $display("[longest_prefix_match_table] OK");
    else
      $display("[longest_prefix_match_table] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[longest_prefix_match_table] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
